@@ design/tsp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the two-gate speed trap.
// No dependencies; imported by every module of the block.
package tsp_pkg;

  localparam int DIST_W  = 24;   // distance registers, micrometers
  localparam int SPEED_W = 32;   // speed results, 0.01 km/h
  localparam int CNT_W   = 16;   // measurement counter
  localparam int NUM_SPD = 4;    // speeds per measurement
  localparam int TS_W    = 32;   // timestamp port width

  // um/us -> 0.01 km/h is a factor of 360.
  localparam int SCALE_W = 9;
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 9'd360;

  // Dividend is distance times the scale factor.
  localparam int DIVD_W = DIST_W + SCALE_W;
  localparam int STEP_W = $clog2(DIVD_W + 1);

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Configuration registers.
  localparam int REG_IDX_W = 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [REG_IDX_W-1:0] REG_BALL_WIDTH   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GATE_SPACING = 1'b1;
  localparam logic [DIST_W-1:0] BALL_WIDTH_RST   = 24'd72000;
  localparam logic [DIST_W-1:0] GATE_SPACING_RST = 24'd101000;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_DIV,
    B_STORE,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ design/tsp_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts edge transactions, keeps the edge times and builds a
// measurement job on every clearing edge of the second barrier. Uses tsp_pkg.
module tsp_front #(
  parameter int TIME_WIDTH = 32,
  parameter int JOB_W      = 4 * TIME_WIDTH + 2 * tsp_pkg::DIST_W + tsp_pkg::CNT_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        barrier,
  input  logic                        level,
  input  logic [tsp_pkg::TS_W-1:0]    timestamp_us,
  input  logic [tsp_pkg::DIST_W-1:0]  ball_width_um,
  input  logic [tsp_pkg::DIST_W-1:0]  gate_spacing_um,
  input  tsp_pkg::q_status_t          q_stat,
  output logic                        push,
  output logic [JOB_W-1:0]            job
);
  import tsp_pkg::*;

  logic [TIME_WIDTH-1:0] first_block_time;
  logic [TIME_WIDTH-1:0] first_clear_time;
  logic [TIME_WIDTH-1:0] second_block_time;
  logic [CNT_W-1:0]      measurement_counter;
  logic [CNT_W-1:0]      measurement_counter_next;
  logic [TIME_WIDTH-1:0] t;
  logic                  accept;
  logic [TIME_WIDTH-1:0] dur0, dur1, dur2, dur3;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign t        = TIME_WIDTH'(timestamp_us);
  assign push     = accept && barrier && level;

  // The second clearing time is only ever used by the job it starts, so the
  // incoming timestamp stands in for it.
  assign dur0 = first_clear_time - first_block_time;
  assign dur1 = t - second_block_time;
  assign dur2 = second_block_time - first_block_time;
  assign dur3 = t - first_clear_time;

  assign measurement_counter_next = measurement_counter + CNT_W'(1);

  assign job = {measurement_counter_next, gate_spacing_um, ball_width_um,
                dur3, dur2, dur1, dur0};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_block_time    <= '0;
      first_clear_time    <= '0;
      second_block_time   <= '0;
      measurement_counter <= '0;
    end else if (accept) begin
      if (!barrier) begin
        if (level) first_clear_time <= t;
        else       first_block_time <= t;
      end else if (!level) begin
        second_block_time <= t;
      end else begin
        measurement_counter <= measurement_counter_next;
      end
    end
  end

endmodule

@@ design/tsp_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the front end and the divider back end.
// Uses tsp_pkg for its depth and status struct.
module tsp_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   head,
  output tsp_pkg::q_status_t q_stat
);
  import tsp_pkg::*;

  logic [WIDTH-1:0]  mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_stat.full  = (count == QCNT_W'(Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ design/tsp_back.sv @@
`timescale 1ns / 1ps
// Back end: runs the four divisions of a job on one restoring divider, one
// quotient bit per cycle, and holds the finished result. Uses tsp_pkg.
module tsp_back #(
  parameter int TIME_WIDTH = 32,
  parameter int JOB_W      = 4 * TIME_WIDTH + 2 * tsp_pkg::DIST_W + tsp_pkg::CNT_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [JOB_W-1:0]            job,
  input  tsp_pkg::q_status_t          q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tsp_pkg::SPEED_W-1:0] speed_first_blocked,
  output logic [tsp_pkg::SPEED_W-1:0] speed_second_blocked,
  output logic [tsp_pkg::SPEED_W-1:0] speed_leading_edges,
  output logic [tsp_pkg::SPEED_W-1:0] speed_trailing_edges,
  output logic [tsp_pkg::NUM_SPD-1:0] zero_duration_mask,
  output logic [tsp_pkg::CNT_W-1:0]   measurement_count
);
  import tsp_pkg::*;

  localparam int LANE_W = $clog2(NUM_SPD);

  back_state_t state, state_next;

  logic [TIME_WIDTH-1:0] dur [NUM_SPD];
  logic [DIST_W-1:0]     ball, gap;
  logic [CNT_W-1:0]      job_cnt;
  logic                  job_valid;

  logic [LANE_W-1:0]     lane;
  logic [STEP_W-1:0]     step;
  logic [DIVD_W-1:0]     dq;
  logic [TIME_WIDTH-1:0] rem;
  logic [SPEED_W-1:0]    spd_w [NUM_SPD];
  logic [NUM_SPD-1:0]    mask_w;

  logic [TIME_WIDTH-1:0] cur_dur;
  logic [DIST_W-1:0]     cur_dist;
  logic [TIME_WIDTH:0]   rem_sh;
  logic                  ge;
  logic [SPEED_W-1:0]    spd_res;
  logic                  last_step;
  logic                  last_lane;
  logic                  out_load;
  logic                  do_load, do_step, do_store;

  assign {job_cnt, gap, ball, dur[3], dur[2], dur[1], dur[0]} = job;
  assign job_valid = !q_stat.empty;

  always_comb begin
    case (lane)
      2'd0:    begin cur_dur = dur[0]; cur_dist = ball; end
      2'd1:    begin cur_dur = dur[1]; cur_dist = ball; end
      2'd2:    begin cur_dur = dur[2]; cur_dist = gap;  end
      default: begin cur_dur = dur[3]; cur_dist = gap;  end
    endcase
  end

  // One restoring division step.
  assign rem_sh = {rem, dq[DIVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, cur_dur});

  // The quotient can reach DIVD_W bits; anything above SPEED_W saturates.
  assign spd_res = (cur_dur == '0) ? SPEED_MAX :
                   (|dq[DIVD_W-1:SPEED_W]) ? SPEED_MAX : dq[SPEED_W-1:0];

  assign last_step = (step == STEP_W'(DIVD_W - 1));
  assign last_lane = (lane == LANE_W'(NUM_SPD - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (job_valid) state_next = B_LOAD;
      B_LOAD:  state_next = B_DIV;
      B_DIV:   if (last_step) state_next = B_STORE;
      B_STORE: state_next = last_lane ? B_OUT : B_LOAD;
      B_OUT:   if (!out_valid || out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    do_load  = 1'b0;
    do_step  = 1'b0;
    do_store = 1'b0;
    out_load = 1'b0;
    unique case (state)
      B_IDLE:  ;
      B_LOAD:  do_load = 1'b1;
      B_DIV:   do_step = 1'b1;
      B_STORE: do_store = 1'b1;
      B_OUT:   out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign pop = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      lane      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_load) step <= '0;
      else if (do_step) step <= step + STEP_W'(1);
      if (do_store) lane <= last_lane ? '0 : lane + LANE_W'(1);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      dq  <= DIVD_W'(cur_dist) * DIVD_W'(SPEED_SCALE);
      rem <= '0;
    end else if (do_step) begin
      dq  <= {dq[DIVD_W-2:0], ge};
      rem <= ge ? TIME_WIDTH'(rem_sh - {1'b0, cur_dur}) : rem_sh[TIME_WIDTH-1:0];
    end
    if (do_store) begin
      spd_w[lane]  <= spd_res;
      mask_w[lane] <= (cur_dur == '0);
    end
    if (out_load) begin
      speed_first_blocked  <= spd_w[0];
      speed_second_blocked <= spd_w[1];
      speed_leading_edges  <= spd_w[2];
      speed_trailing_edges <= spd_w[3];
      zero_duration_mask   <= mask_w;
      measurement_count    <= job_cnt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (step < STEP_W'(DIVD_W)))
    else $error("divider step count ran past the dividend width");

  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> job_valid)
    else $error("job popped from an empty queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !$past(out_load))
    else $error("pending result overwritten");

  a_load_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == B_LOAD) |=> (state == B_DIV) && (step == '0))
    else $error("division did not start from step zero");

  a_zero_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!zero_duration_mask[0] || speed_first_blocked == SPEED_MAX) &&
                  (!zero_duration_mask[1] || speed_second_blocked == SPEED_MAX) &&
                  (!zero_duration_mask[2] || speed_leading_edges == SPEED_MAX) &&
                  (!zero_duration_mask[3] || speed_trailing_edges == SPEED_MAX))
    else $error("zero duration without a saturated speed");

endmodule

@@ design/two_gate_speed_trap_top.sv @@
`timescale 1ns / 1ps
// Top level of the two-gate speed trap: configuration registers and the
// front end, job queue and divider back end. Uses tsp_pkg and all tsp_ modules.
//
//   Channel  | Handshake              | Transaction carries
//   ---------+------------------------+----------------------------------------
//   config   | psel/penable/pwrite    | paddr, pwdata (reads return prdata)
//   in       | in_valid / in_ready    | barrier, level, timestamp_us
//   out      | out_valid / out_ready  | four speeds, zero_duration_mask,
//            |                        | measurement_count
//
// A clearing edge of the second barrier queues a job; the back end runs four
// 33-step restoring divisions on one shared divider, then loads the result
// into the output register.
// Reset (synchronous, active high) clears all edge times, the measurement
// counter, the queue and the output valid, and restores the register defaults.
// A result held in the output register stalls the back end only when the next
// job has finished while it still waits; in_ready drops only while the
// two-entry job queue is full.
module two_gate_speed_trap_top #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tsp_pkg::PADDR_W-1:0]  paddr,
  input  logic [tsp_pkg::PDATA_W-1:0]  pwdata,
  output logic [tsp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // edge events
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         barrier,
  input  logic                         level,
  input  logic [tsp_pkg::TS_W-1:0]     timestamp_us,
  // measurements
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tsp_pkg::SPEED_W-1:0]  speed_first_blocked,
  output logic [tsp_pkg::SPEED_W-1:0]  speed_second_blocked,
  output logic [tsp_pkg::SPEED_W-1:0]  speed_leading_edges,
  output logic [tsp_pkg::SPEED_W-1:0]  speed_trailing_edges,
  output logic [tsp_pkg::NUM_SPD-1:0]  zero_duration_mask,
  output logic [tsp_pkg::CNT_W-1:0]    measurement_count
);
  import tsp_pkg::*;

  localparam int JOB_W = 4 * TIME_WIDTH + 2 * DIST_W + CNT_W;

  logic [DIST_W-1:0]    ball_width_um;
  logic [DIST_W-1:0]    gate_spacing_um;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  logic                 push;
  logic                 pop;
  logic [JOB_W-1:0]     push_job;
  logic [JOB_W-1:0]     head_job;
  q_status_t            q_stat;

  // Registers sit on 4-byte boundaries; the word index is the bit above the
  // byte offset. Any address decodes to one of the two registers.
  assign reg_idx   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ball_width_um   <= BALL_WIDTH_RST;
      gate_spacing_um <= GATE_SPACING_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_BALL_WIDTH:   ball_width_um   <= pwdata[DIST_W-1:0];
        REG_GATE_SPACING: gate_spacing_um <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BALL_WIDTH:   prdata = PDATA_W'(ball_width_um);
      REG_GATE_SPACING: prdata = PDATA_W'(gate_spacing_um);
      default:          prdata = '0;
    endcase
  end

  // Front end records edge times and builds a job with a snapshot of the
  // distances and the new measurement number.
  tsp_front #(
    .TIME_WIDTH (TIME_WIDTH),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .barrier         (barrier),
    .level           (level),
    .timestamp_us    (timestamp_us),
    .ball_width_um   (ball_width_um),
    .gate_spacing_um (gate_spacing_um),
    .q_stat          (q_stat),
    .push            (push),
    .job             (push_job)
  );

  // Jobs wait here so the front end keeps taking edges while the divider runs.
  tsp_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head_job),
    .q_stat    (q_stat)
  );

  // Back end divides and holds the finished measurement until it is taken.
  tsp_back #(
    .TIME_WIDTH (TIME_WIDTH),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .job                  (head_job),
    .q_stat               (q_stat),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .speed_first_blocked  (speed_first_blocked),
    .speed_second_blocked (speed_second_blocked),
    .speed_leading_edges  (speed_leading_edges),
    .speed_trailing_edges (speed_trailing_edges),
    .zero_duration_mask   (zero_duration_mask),
    .measurement_count    (measurement_count)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the two-gate speed trap top level.
// Depends only on tsp_pkg and two_gate_speed_trap_top from the design folder.
module tb_top;

  import tsp_pkg::*;

  // Quiet time before a register write, ample for the back end to finish a
  // measurement.
  localparam int SETTLE_CYCLES = 200;
  // Watchdog limit, far above the slowest correct run.
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_WAIT      = 14;

  // One measurement as it appears on the output channel. Speed index i matches
  // bit i of the zero-duration mask.
  typedef struct packed {
    logic [NUM_SPD-1:0][SPEED_W-1:0] speed;
    logic [NUM_SPD-1:0]              zero_mask;
    logic [CNT_W-1:0]                count;
  } measurement_t;

  // Scoreboard: mirrors the edge times and the distance registers, computes the
  // four speeds on each clearing edge of the second barrier and holds them
  // until the matching output transaction arrives.
  class speed_trap_scoreboard;
    logic [DIST_W-1:0]  ball_width_um;
    logic [DIST_W-1:0]  gate_spacing_um;
    logic [TS_W-1:0]    first_block;
    logic [TS_W-1:0]    first_clear;
    logic [TS_W-1:0]    second_block;
    logic [TS_W-1:0]    second_clear;
    logic [CNT_W-1:0]   meas_count;
    measurement_t       awaited[$];
    int                 errors;
    int                 checked;

    function new();
      ball_width_um   = BALL_WIDTH_RST;
      gate_spacing_um = GATE_SPACING_RST;
      first_block     = '0;
      first_clear     = '0;
      second_block    = '0;
      second_clear    = '0;
      meas_count      = '0;
      errors          = 0;
      checked         = 0;
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      if (idx == REG_BALL_WIDTH) begin
        ball_width_um = value[DIST_W-1:0];
      end else if (idx == REG_GATE_SPACING) begin
        gate_spacing_um = value[DIST_W-1:0];
      end
    endfunction

    // Distance times 360 over duration, truncated, saturating at all ones.
    function logic [SPEED_W-1:0] speed_for(logic [DIST_W-1:0] dist_um, logic [TS_W-1:0] dur,
                                           output logic zero);
      logic [63:0] quot;
      zero = (dur == '0);
      if (zero) begin
        return SPEED_MAX;
      end
      quot = ({40'd0, dist_um} * 64'd360) / {32'd0, dur};
      return (quot > 64'hFFFF_FFFF) ? SPEED_MAX : quot[SPEED_W-1:0];
    endfunction

    function void note_edge(logic bar, logic lvl, logic [TS_W-1:0] ts);
      measurement_t              m;
      logic [NUM_SPD-1:0][TS_W-1:0] dur;
      logic [NUM_SPD-1:0][DIST_W-1:0] dist_um;
      logic                      z;
      if (bar == 1'b0) begin
        if (lvl) first_clear = ts;
        else first_block = ts;
        return;
      end
      if (lvl == 1'b0) begin
        second_block = ts;
        return;
      end
      second_clear = ts;
      dur[0]  = first_clear - first_block;
      dur[1]  = second_clear - second_block;
      dur[2]  = second_block - first_block;
      dur[3]  = second_clear - first_clear;
      dist_um[0] = ball_width_um;
      dist_um[1] = ball_width_um;
      dist_um[2] = gate_spacing_um;
      dist_um[3] = gate_spacing_um;
      for (int i = 0; i < NUM_SPD; i++) begin
        m.speed[i]     = speed_for(dist_um[i], dur[i], z);
        m.zero_mask[i] = z;
      end
      meas_count = meas_count + 1'b1;
      m.count    = meas_count;
      awaited.push_back(m);
    endfunction

    function void check_measurement(measurement_t got);
      measurement_t exp_m;
      string        names[NUM_SPD];
      names = '{"speed_first_blocked", "speed_second_blocked",
                "speed_leading_edges", "speed_trailing_edges"};
      if (awaited.size() == 0) begin
        $error("measurement with no expectation pending: count %0d", got.count);
        errors++;
        return;
      end
      exp_m = awaited.pop_front();
      checked++;
      for (int i = 0; i < NUM_SPD; i++) begin
        if (got.speed[i] !== exp_m.speed[i]) begin
          $error("%s: expected %0d, got %0d", names[i], exp_m.speed[i], got.speed[i]);
          errors++;
        end
      end
      if (got.zero_mask !== exp_m.zero_mask) begin
        $error("zero_duration_mask: expected %b, got %b", exp_m.zero_mask, got.zero_mask);
        errors++;
      end
      if (got.count !== exp_m.count) begin
        $error("measurement_count: expected %0d, got %0d", exp_m.count, got.count);
        errors++;
      end
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic               barrier      = 1'b0;
  logic               level        = 1'b0;
  logic [TS_W-1:0]    timestamp_us = '0;

  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [SPEED_W-1:0] speed_first_blocked;
  logic [SPEED_W-1:0] speed_second_blocked;
  logic [SPEED_W-1:0] speed_leading_edges;
  logic [SPEED_W-1:0] speed_trailing_edges;
  logic [NUM_SPD-1:0] zero_duration_mask;
  logic [CNT_W-1:0]   measurement_count;

  speed_trap_scoreboard sb;
  int  edges_sent   = 0;
  int  settings_run = 0;
  // When set, both sides stop idling; toggled at random by the stimulus so the
  // run mixes back-to-back stretches with gappy ones.
  bit  no_idle      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  two_gate_speed_trap_top DUT (
    .clk                  (clk),
    .rst                  (rst),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .barrier              (barrier),
    .level                (level),
    .timestamp_us         (timestamp_us),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .speed_first_blocked  (speed_first_blocked),
    .speed_second_blocked (speed_second_blocked),
    .speed_leading_edges  (speed_leading_edges),
    .speed_trailing_edges (speed_trailing_edges),
    .zero_duration_mask   (zero_duration_mask),
    .measurement_count    (measurement_count)
  );

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Durations drawn from classes that hit zero, one, realistic ball times,
  // huge values and values just short of a full wrap of the time base.
  function automatic logic [TS_W-1:0] random_duration();
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return 32'd1;
      end
      2: begin
        return $urandom_range(2, 60);
      end
      3, 4, 5: begin
        return $urandom_range(1000, 400000);
      end
      6: begin
        return $urandom_range(400000, 50000000);
      end
      7: begin
        return $urandom;
      end
      8: begin
        return 32'hFFFF_FFFF - $urandom_range(0, 50);
      end
      default: begin
        return $urandom_range(61, 999);
      end
    endcase
  endfunction

  // Every task below is entered right after a rising edge and returns right
  // after one, so all drives happen in the step of a rising edge. Valid is
  // lowered only when a gap follows, which keeps it at one assignment per step.
  task automatic send_edge(input logic bar, input logic lvl, input logic [TS_W-1:0] ts);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    barrier      <= bar;
    level        <= lvl;
    timestamp_us <= ts;
    do @(posedge clk); while (!in_ready);
    // The transaction was taken at this edge.
    sb.note_edge(bar, lvl, ts);
    edges_sent++;
  endtask

  // Drains the block before a register write: every measurement must be back,
  // then the back end gets time to go fully quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write; the upper byte of the data is random junk that
  // the block has to mask away. The bus returns to idle afterwards.
  task automatic write_distance(input logic [REG_IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
    logic [PDATA_W-1:0] data;
    data    = {8'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [DIST_W-1:0] width, input logic [DIST_W-1:0] spacing);
    wait_idle();
    write_distance(REG_BALL_WIDTH, width);
    write_distance(REG_GATE_SPACING, spacing);
    settings_run++;
  endtask

  // A ball passing both gates: block first, then the second gate blocks and
  // the first clears in either order, then the second clears. A broken pass
  // leaves out a blocking edge or the first clear, so stale times get used.
  task automatic ball_pass(input bit broken);
    logic [TS_W-1:0] t0, lead, w1, w2;
    int              skip;
    t0   = $urandom;
    lead = random_duration();
    w1   = random_duration();
    w2   = random_duration();
    skip = broken ? $urandom_range(0, 2) : 3;
    if (skip != 0) send_edge(1'b0, 1'b0, t0);
    if ($urandom_range(0, 1) == 1) begin
      if (skip != 1) send_edge(1'b1, 1'b0, t0 + lead);
      if (skip != 2) send_edge(1'b0, 1'b1, t0 + w1);
    end else begin
      if (skip != 2) send_edge(1'b0, 1'b1, t0 + w1);
      if (skip != 1) send_edge(1'b1, 1'b0, t0 + lead);
    end
    send_edge(1'b1, 1'b1, t0 + lead + w2);
  endtask

  task automatic random_traffic(input int n_edges);
    int target;
    int pick;
    target = edges_sent + n_edges;
    while (edges_sent < target) begin
      if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        ball_pass(1'b0);
      end else if (pick < 9) begin
        ball_pass(1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  // Receiver: draws a stall before each measurement and checks every
  // transaction against the oldest prediction.
  initial begin
    int           stall;
    measurement_t got;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.speed[0]  = speed_first_blocked;
      got.speed[1]  = speed_second_blocked;
      got.speed[2]  = speed_leading_edges;
      got.speed[3]  = speed_trailing_edges;
      got.zero_mask = zero_duration_mask;
      got.count     = measurement_count;
      sb.check_measurement(got);
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset distances. A clearing edge of the second
    // barrier straight after reset sees only zero times, so every duration is
    // zero and all four speeds saturate with the full mask set.
    send_edge(1'b1, 1'b1, 32'h0000_0000);
    // All-ones timestamp against zeros from reset: nearly a full wrap.
    send_edge(1'b1, 1'b1, 32'hFFFF_FFFF);
    // An ordinary pass.
    send_edge(1'b0, 1'b0, 32'd1000);
    send_edge(1'b1, 1'b0, 32'd3000);
    send_edge(1'b0, 1'b1, 32'd2200);
    send_edge(1'b1, 1'b1, 32'd4100);
    // A pass across the wrap of the time base.
    send_edge(1'b0, 1'b0, 32'hFFFF_FFF0);
    send_edge(1'b0, 1'b1, 32'h0000_000A);
    send_edge(1'b1, 1'b0, 32'h0000_0010);
    send_edge(1'b1, 1'b1, 32'h0000_0030);
    // Both gates block and clear at the same instant: every duration zero.
    send_edge(1'b0, 1'b0, 32'd500);
    send_edge(1'b0, 1'b1, 32'd500);
    send_edge(1'b1, 1'b0, 32'd500);
    send_edge(1'b1, 1'b1, 32'd500);
    // Alternating bit patterns, and a repeated clear with no new blocking edge.
    send_edge(1'b1, 1'b0, 32'hAAAA_AAAA);
    send_edge(1'b1, 1'b1, 32'h5555_5555);
    send_edge(1'b1, 1'b1, 32'h5555_5556);
    settings_run++;
    random_traffic(120);

    // Zero ball width and the largest gate spacing.
    load_setting(24'd0, 24'hFF_FFFF);
    random_traffic(110);

    // Largest ball width and zero spacing. A one-microsecond blocked time
    // overflows 32 bits and must saturate without raising a flag.
    load_setting(24'hFF_FFFF, 24'd0);
    send_edge(1'b0, 1'b0, 32'd10);
    send_edge(1'b0, 1'b1, 32'd11);
    send_edge(1'b1, 1'b0, 32'd11);
    send_edge(1'b1, 1'b1, 32'd12);
    random_traffic(110);

    load_setting(24'($urandom), 24'($urandom));
    random_traffic(110);

    load_setting(24'($urandom_range(1, 500000)), 24'($urandom_range(1, 500000)));
    random_traffic(110);

    // Back to the reset distances by explicit writes.
    load_setting(BALL_WIDTH_RST, GATE_SPACING_RST);
    random_traffic(40);

    wait_idle();
    $display("Sent %0d edge transactions under %0d distance settings.",
             edges_sent, settings_run);
    $display("Checked %0d measurements, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
